[design/kmrb_pkg.sv]
// Shared types, constants and key tables for the key matrix report builder.
package kmrb_pkg;

    localparam int ROWS     = 3;
    localparam int COLS     = 4;
    localparam int NUM_KEYS = ROWS * COLS;
    localparam int MAX_KEYS = 12;
    localparam int KEY_W    = $clog2(NUM_KEYS);
    localparam int CNT_W    = $clog2(MAX_KEYS + 1);
    localparam int CODE_W   = 8;
    localparam int LED_W    = 12;

    localparam logic [KEY_W-1:0] LAST_POS     = KEY_W'(NUM_KEYS - 1);
    localparam logic [KEY_W-1:0] VOL_UP_POS   = KEY_W'(1 * COLS + 3);
    localparam logic [KEY_W-1:0] VOL_DOWN_POS = KEY_W'(2 * COLS + 3);

    localparam logic [CODE_W-1:0] KC_F1    = 8'h3A;
    localparam logic [CODE_W-1:0] KC_F2    = 8'h3B;
    localparam logic [CODE_W-1:0] KC_F3    = 8'h3C;
    localparam logic [CODE_W-1:0] KC_ESC   = 8'h29;
    localparam logic [CODE_W-1:0] KC_A     = 8'h04;
    localparam logic [CODE_W-1:0] KC_UP    = 8'h52;
    localparam logic [CODE_W-1:0] KC_DEL   = 8'h4C;
    localparam logic [CODE_W-1:0] KC_LEFT  = 8'h50;
    localparam logic [CODE_W-1:0] KC_DOWN  = 8'h51;
    localparam logic [CODE_W-1:0] KC_RIGHT = 8'h4F;
    localparam logic [CODE_W-1:0] KC_NONE  = 8'h00;

    localparam logic KIND_CONSUMER = 1'b0;
    localparam logic KIND_KEYBOARD = 1'b1;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_APPEND,
        CELL_REMOVE,
        CELL_ROTATE
    } t_cell_op;

    typedef struct packed {
        t_cell_op            op;
        logic [CODE_W-1:0]   code;
        logic [CNT_W-1:0]    count;
    } t_cell_ctl;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EVENT,
        ST_REPORT
    } t_state;

    function automatic logic [CODE_W-1:0] key_code(input logic [KEY_W-1:0] pos);
        logic [CODE_W-1:0] code;
        case (pos)
            4'd0:    code = KC_F1;
            4'd1:    code = KC_F2;
            4'd2:    code = KC_F3;
            4'd3:    code = KC_ESC;
            4'd4:    code = KC_A;
            4'd5:    code = KC_UP;
            4'd6:    code = KC_DEL;
            4'd8:    code = KC_LEFT;
            4'd9:    code = KC_DOWN;
            4'd10:   code = KC_RIGHT;
            default: code = KC_NONE;
        endcase
        return code;
    endfunction

    function automatic logic [3:0] led_pos(input logic [KEY_W-1:0] pos);
        logic [3:0] led;
        case (pos)
            4'd0:    led = 4'd3;
            4'd1:    led = 4'd2;
            4'd2:    led = 4'd1;
            4'd3:    led = 4'd0;
            4'd4:    led = 4'd4;
            4'd5:    led = 4'd5;
            4'd6:    led = 4'd6;
            4'd7:    led = 4'd7;
            4'd8:    led = 4'd11;
            4'd9:    led = 4'd10;
            4'd10:   led = 4'd9;
            4'd11:   led = 4'd8;
            default: led = 4'd0;
        endcase
        return led;
    endfunction

    function automatic logic [LED_W-1:0] led_map(input logic [NUM_KEYS-1:0] keys);
        logic [LED_W-1:0] leds;
        leds = '0;
        for (int i = 0; i < NUM_KEYS; i++) begin
            leds[led_pos(KEY_W'(i))] = keys[i];
        end
        return leds;
    endfunction

    function automatic logic is_volume(input logic [KEY_W-1:0] pos);
        return (pos == VOL_UP_POS) || (pos == VOL_DOWN_POS);
    endfunction

endpackage

[design/kmrb_cell.sv]
// One entry of the pressed-key list; entries shift toward cell 0 on remove and rotate.
module kmrb_cell
    import kmrb_pkg::*;
(
    input  logic              i_clk,
    input  logic [CNT_W-1:0]  i_idx,
    input  t_cell_ctl         i_ctl,
    input  logic [CODE_W-1:0] i_right_code,
    input  logic [CODE_W-1:0] i_wrap_code,
    input  logic              i_match,
    output logic              o_match,
    output logic [CODE_W-1:0] o_code
);

    logic [CODE_W-1:0] r_code;
    logic [CODE_W-1:0] n_code;
    logic              w_live;
    logic              w_hit;

    assign w_live  = i_idx < i_ctl.count;
    assign w_hit   = (i_ctl.op == CELL_REMOVE) && w_live && (r_code == i_ctl.code);
    // match ripples right: every live cell at or past the hit pulls its neighbor in
    assign o_match = i_match | w_hit;
    assign o_code  = r_code;

    always_comb begin
        n_code = r_code;
        case (i_ctl.op)
            CELL_APPEND: begin
                if (i_idx == i_ctl.count) begin
                    n_code = i_ctl.code;
                end
            end
            CELL_REMOVE: begin
                if (o_match && w_live) begin
                    n_code = i_right_code;
                end
            end
            CELL_ROTATE: begin
                // head goes to the tail of the live region
                n_code = (i_idx == i_ctl.count - CNT_W'(1)) ? i_wrap_code : i_right_code;
            end
            default: n_code = r_code;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_code <= n_code;
    end

endmodule

[design/key_matrix_report_builder_core.sv]
// Top level: scan sequencer, volume events and report emission over the list cell chain.
//
// Input channel s_axis: one item is one 12-bit matrix scan (bit row*4+col set = pressed).
// Output channel m_axis: result items. tuser is the kind (0 volume event, 1 report
// entry), tlast marks the final result of a scan.
// The scan is walked one key position per cycle, updating the list
// held in a chain of 12 cells (append at the tail, remove with shift-down).
// Then up to two volume events are sent, then the report: one entry per listed
// code, taken from cell 0 while the chain rotates by one per entry sent, or one
// reserved-code entry when the list is empty.
// Input ready is high only between scans; a scan can be taken while the last
// result still waits in the output register.
// A stall on m_axis freezes emission and the chain rotation; nothing is lost.
// Reset (i_rst_n low, synchronous) clears the previous scan, the list count
// and the output valid; list contents need no clearing.
module key_matrix_report_builder_core
    import kmrb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [11:0] keys_down, [15:12] zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [0] volume_key, [1] volume_pressed,
                                        // [9:2] key_code, [13:10] report_count,
                                        // [25:14] led_mask, [31:26] zero
    output logic        m_axis_tuser,   // [0] kind
    output logic        m_axis_tlast    // is_last
);

    t_state            r_state, n_state;
    logic [NUM_KEYS-1:0] r_now, n_now;
    logic [NUM_KEYS-1:0] r_prev, n_prev;
    logic [LED_W-1:0]  r_leds, n_leds;
    logic [KEY_W-1:0]  r_pos, n_pos;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [CNT_W-1:0]  r_emit, n_emit;
    logic [1:0]        r_nev, n_nev;
    logic              r_ev_idx, n_ev_idx;
    logic [1:0]        r_ev_key, n_ev_key;
    logic [1:0]        r_ev_press, n_ev_press;

    logic              r_tvalid, n_tvalid;
    logic              r_kind, n_kind;
    logic              r_vkey, n_vkey;
    logic              r_vpress, n_vpress;
    logic [CODE_W-1:0] r_code, n_code;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [LED_W-1:0]  r_oleds, n_oleds;
    logic              r_last, n_last;

    t_cell_ctl         w_ctl;
    logic [CODE_W-1:0] w_code [MAX_KEYS+1];
    logic              w_match [MAX_KEYS+1];
    logic              w_out_free;
    logic              w_cur;
    logic              w_old;
    logic              w_last_entry;

    assign w_out_free   = !r_tvalid || m_axis_tready;
    assign w_cur        = r_now[r_pos];
    assign w_old        = r_prev[r_pos];
    assign w_last_entry = (r_cnt == '0) || (r_emit == r_cnt - CNT_W'(1));

    assign w_match[0]        = 1'b0;
    assign w_code[MAX_KEYS]  = '0;

    for (genvar g = 0; g < MAX_KEYS; g++) begin : g_cell
        kmrb_cell u_cell (
            .i_clk        (i_clk),
            .i_idx        (CNT_W'(g)),
            .i_ctl        (w_ctl),
            .i_right_code (w_code[g+1]),
            .i_wrap_code  (w_code[0]),
            .i_match      (w_match[g]),
            .o_match      (w_match[g+1]),
            .o_code       (w_code[g])
        );
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_pos == LAST_POS) begin
                    n_state = (n_nev != '0) ? ST_EVENT : ST_REPORT;
                end
            end
            ST_EVENT: begin
                if (w_out_free && ({1'b0, r_ev_idx} == r_nev - 2'd1)) begin
                    n_state = ST_REPORT;
                end
            end
            ST_REPORT: begin
                if (w_out_free && w_last_entry) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_now      = r_now;
        n_prev     = r_prev;
        n_leds     = r_leds;
        n_pos      = r_pos;
        n_cnt      = r_cnt;
        n_emit     = r_emit;
        n_nev      = r_nev;
        n_ev_idx   = r_ev_idx;
        n_ev_key   = r_ev_key;
        n_ev_press = r_ev_press;
        n_tvalid   = r_tvalid && !m_axis_tready;
        n_kind     = r_kind;
        n_vkey     = r_vkey;
        n_vpress   = r_vpress;
        n_code     = r_code;
        n_count    = r_count;
        n_oleds    = r_oleds;
        n_last     = r_last;
        w_ctl.op    = CELL_HOLD;
        w_ctl.code  = key_code(r_pos);
        w_ctl.count = r_cnt;
        s_axis_tready = (r_state == ST_IDLE);
        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_now  = s_axis_tdata[NUM_KEYS-1:0];
                    n_leds = led_map(s_axis_tdata[NUM_KEYS-1:0]);
                    n_pos  = '0;
                    n_nev  = '0;
                end
            end
            ST_SCAN: begin
                if (w_cur != w_old) begin
                    if (is_volume(r_pos)) begin
                        n_ev_key[r_nev[0]]   = (r_pos == VOL_DOWN_POS);
                        n_ev_press[r_nev[0]] = w_cur;
                        n_nev                = r_nev + 2'd1;
                    end else if (w_cur) begin
                        if (r_cnt < CNT_W'(MAX_KEYS)) begin
                            w_ctl.op = CELL_APPEND;
                            n_cnt    = r_cnt + CNT_W'(1);
                        end
                    end else begin
                        w_ctl.op = CELL_REMOVE;
                        if (w_match[MAX_KEYS]) begin
                            n_cnt = r_cnt - CNT_W'(1);
                        end
                    end
                end
                n_pos = r_pos + KEY_W'(1);
                if (r_pos == LAST_POS) begin
                    n_prev   = r_now;
                    n_ev_idx = 1'b0;
                    n_emit   = '0;
                end
            end
            ST_EVENT: begin
                if (w_out_free) begin
                    n_tvalid = 1'b1;
                    n_kind   = KIND_CONSUMER;
                    n_vkey   = r_ev_key[r_ev_idx];
                    n_vpress = r_ev_press[r_ev_idx];
                    n_code   = KC_NONE;
                    n_count  = r_cnt;
                    n_oleds  = r_leds;
                    n_last   = 1'b0;
                    n_ev_idx = ~r_ev_idx;
                end
            end
            ST_REPORT: begin
                if (w_out_free) begin
                    n_tvalid = 1'b1;
                    n_kind   = KIND_KEYBOARD;
                    n_vkey   = 1'b0;
                    n_vpress = 1'b0;
                    n_count  = r_cnt;
                    n_oleds  = r_leds;
                    n_last   = w_last_entry;
                    if (r_cnt == '0) begin
                        n_code = KC_NONE;
                    end else begin
                        n_code   = w_code[0];
                        w_ctl.op = CELL_ROTATE;
                        n_emit   = r_emit + CNT_W'(1);
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_prev   <= '0;
            r_cnt    <= '0;
            r_pos    <= '0;
            r_emit   <= '0;
            r_nev    <= '0;
            r_ev_idx <= 1'b0;
            r_tvalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_prev   <= n_prev;
            r_cnt    <= n_cnt;
            r_pos    <= n_pos;
            r_emit   <= n_emit;
            r_nev    <= n_nev;
            r_ev_idx <= n_ev_idx;
            r_tvalid <= n_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_now      <= n_now;
        r_leds     <= n_leds;
        r_ev_key   <= n_ev_key;
        r_ev_press <= n_ev_press;
        r_kind     <= n_kind;
        r_vkey     <= n_vkey;
        r_vpress   <= n_vpress;
        r_code     <= n_code;
        r_count    <= n_count;
        r_oleds    <= n_oleds;
        r_last     <= n_last;
    end

    assign m_axis_tvalid = r_tvalid;
    assign m_axis_tuser  = r_kind;
    assign m_axis_tlast  = r_last;
    assign m_axis_tdata  = {6'd0, r_oleds, r_count, r_code, r_vpress, r_vkey};

endmodule

[verif/kmrb_report_checker.sv]
// Checker for the key matrix report builder: predicts each scan's result items and compares them.
module kmrb_report_checker
    import kmrb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_scan_valid,
    input  logic        i_scan_ready,
    input  logic [15:0] i_scan_data,
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic [31:0] i_res_data,
    input  logic        i_res_user,
    input  logic        i_res_last,
    output int          o_failures,
    output int          o_pending,
    output int          o_results,
    output int          o_events
);

    typedef struct packed {
        logic              kind;
        logic              vol_key;
        logic              vol_pressed;
        logic [CODE_W-1:0] code;
        logic [3:0]        count;
        logic [LED_W-1:0]  leds;
        logic              last;
    } t_report_item;

    // usage code per matrix position, position 0 in the low byte; volume keys hold reserved
    localparam logic [NUM_KEYS*CODE_W-1:0] CODE_TABLE = {
        KC_NONE, KC_RIGHT, KC_DOWN, KC_LEFT,
        KC_NONE, KC_DEL,   KC_UP,   KC_A,
        KC_ESC,  KC_F3,    KC_F2,   KC_F1
    };

    // LED index per matrix position, position 0 in the low nibble
    localparam logic [NUM_KEYS*4-1:0] LED_TABLE = {
        4'd8, 4'd9,  4'd10, 4'd11,
        4'd7, 4'd6,  4'd5,  4'd4,
        4'd0, 4'd1,  4'd2,  4'd3
    };

    logic [NUM_KEYS-1:0] held_keys = '0;
    logic [CODE_W-1:0]   key_list [MAX_KEYS];
    int                  key_list_len = 0;
    t_report_item        due_items [$];
    t_report_item        want;
    int                  mismatches = 0;
    int                  results_seen = 0;
    int                  events_seen = 0;

    function automatic void drop_code(input logic [CODE_W-1:0] code);
        int hit;
        hit = -1;
        for (int i = 0; i < key_list_len; i++) begin
            if (hit < 0 && key_list[i] == code) begin
                hit = i;
            end
        end
        // a code that is not listed leaves the list alone
        if (hit >= 0) begin
            for (int i = hit; i < key_list_len - 1; i++) begin
                key_list[i] = key_list[i + 1];
            end
            key_list_len--;
        end
    endfunction

    function automatic void predict_scan(input logic [NUM_KEYS-1:0] now);
        logic [LED_W-1:0] leds;
        logic [1:0]       ev_key;
        logic [1:0]       ev_press;
        int               nev;
        int               n;
        logic [3:0]       cnt;
        leds     = '0;
        ev_key   = '0;
        ev_press = '0;
        nev      = 0;
        n        = 0;
        for (int k = 0; k < NUM_KEYS; k++) begin
            if (now[k] != held_keys[k]) begin
                if (k == VOL_UP_POS || k == VOL_DOWN_POS) begin
                    if (nev < 2) begin
                        ev_key[nev]   = (k == VOL_DOWN_POS);
                        ev_press[nev] = now[k];
                        nev++;
                    end
                end else if (now[k]) begin
                    // a press with the list full is dropped
                    if (key_list_len < MAX_KEYS) begin
                        key_list[key_list_len] = CODE_TABLE[k*CODE_W +: CODE_W];
                        key_list_len++;
                    end
                end else begin
                    drop_code(CODE_TABLE[k*CODE_W +: CODE_W]);
                end
            end
            if (now[k]) begin
                leds[LED_TABLE[k*4 +: 4]] = 1'b1;
            end
        end
        held_keys = now;
        cnt = (key_list_len > 15) ? 4'd15 : 4'(key_list_len);

        for (int v = 0; v < nev; v++) begin
            due_items.push_back('{KIND_CONSUMER, ev_key[v], ev_press[v], KC_NONE,
                                  cnt, leds, 1'b0});
            n++;
        end
        if (key_list_len == 0) begin
            due_items.push_back('{KIND_KEYBOARD, 1'b0, 1'b0, KC_NONE, 4'd0, leds, 1'b0});
        end else begin
            for (int i = 0; i < key_list_len && n < MAX_KEYS; i++) begin
                due_items.push_back('{KIND_KEYBOARD, 1'b0, 1'b0, key_list[i], cnt, leds, 1'b0});
                n++;
            end
        end
        due_items[due_items.size() - 1].last = 1'b1;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] exp_val,
                                        input logic [31:0] got_val);
        if (got_val !== exp_val) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, got_val);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            held_keys    = '0;
            key_list_len = 0;
            due_items.delete();
        end else begin
            if (i_res_valid && i_res_ready) begin
                results_seen++;
                if (due_items.size() == 0) begin
                    $error("result item arrived with no result expected");
                    mismatches++;
                end else begin
                    want = due_items.pop_front();
                    check_field("kind",           32'(want.kind),        32'(i_res_user));
                    check_field("volume_key",     32'(want.vol_key),     32'(i_res_data[0]));
                    check_field("volume_pressed", 32'(want.vol_pressed), 32'(i_res_data[1]));
                    check_field("key_code",       32'(want.code),        32'(i_res_data[9:2]));
                    check_field("report_count",   32'(want.count),       32'(i_res_data[13:10]));
                    check_field("led_mask",       32'(want.leds),        32'(i_res_data[25:14]));
                    check_field("tdata_pad",      32'd0,                 32'(i_res_data[31:26]));
                    check_field("is_last",        32'(want.last),        32'(i_res_last));
                    if (want.kind == KIND_CONSUMER) begin
                        events_seen++;
                    end
                end
            end
            if (i_scan_valid && i_scan_ready) begin
                predict_scan(i_scan_data[NUM_KEYS-1:0]);
            end
        end
        o_failures <= mismatches;
        o_pending  <= due_items.size();
        o_results  <= results_seen;
        o_events   <= events_seen;
    end

endmodule

[verif/tb_key_matrix_report_builder_core.sv]
// Testbench top for the key matrix report builder: scan stimulus, output stalls and verdict.
module tb_key_matrix_report_builder_core;
    import kmrb_pkg::*;

    localparam int RANDOM_SCANS = 360;
    localparam int LONG_HOLD    = 300;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;     // [11:0] keys_down, [15:12] zero
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;          // [0] volume_key, [1] volume_pressed, [9:2] key_code,
                                        // [13:10] report_count, [25:14] led_mask, [31:26] zero
    logic        m_axis_tuser;          // [0] kind
    logic        m_axis_tlast;

    int          failures;
    int          pending;
    int          results;
    int          events;
    int          hold_asks = 0;
    int          hold_served = 0;
    int          scans_sent = 0;
    logic [11:0] keys_now = '0;

    always #5 i_clk = ~i_clk;

    key_matrix_report_builder_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    kmrb_report_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_scan_valid (s_axis_tvalid),
        .i_scan_ready (s_axis_tready),
        .i_scan_data  (s_axis_tdata),
        .i_res_valid  (m_axis_tvalid),
        .i_res_ready  (m_axis_tready),
        .i_res_data   (m_axis_tdata),
        .i_res_user   (m_axis_tuser),
        .i_res_last   (m_axis_tlast),
        .o_failures   (failures),
        .o_pending    (pending),
        .o_results    (results),
        .o_events     (events)
    );

    task automatic send_scan(input logic [11:0] keys);
        s_axis_tdata  <= {4'b0000, keys};
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        scans_sent++;
    endtask

    task automatic idle_sender(input int cycles);
        if (cycles > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // pending is a registered copy of the checker's queue size, hence the wait up front
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // mostly one or two key edges per scan so the list builds up in varied orders
    function automatic logic [11:0] next_scan(input logic [11:0] prev);
        logic [11:0] keys;
        int          a;
        int          b;
        keys = prev;
        a    = $urandom_range(0, 11);
        b    = $urandom_range(0, 11);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: keys[a] = ~keys[a];
            6, 7: begin
                keys[a] = ~keys[a];
                keys[b] = ~keys[b];
            end
            8: keys = 12'($urandom);
            default: keys = ($urandom_range(0, 1) != 0) ? 12'hFFF : 12'h000;
        endcase
        return keys;
    endfunction

    // output side: stall pattern changes every span; a long hold-off when asked
    initial begin : result_sink
        int mode;
        int span;
        int phase;
        phase = 0;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(10, 120);
            repeat (span) begin
                @(posedge i_clk);
                if (hold_asks != hold_served) begin
                    hold_served++;
                    m_axis_tready <= 1'b0;
                    repeat (LONG_HOLD) @(posedge i_clk);
                end
                phase++;
                case (mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= ($urandom_range(0, 2) != 0);
                    2: m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default: m_axis_tready <= (phase % 5 != 4);
                endcase
            end
        end
    end

    initial begin : scan_source
        logic [11:0] opening [23];
        int          burst;
        int          n;
        // empty report, all keys, volume edges, list removal from middle and head,
        // several edges in one scan, alternating patterns
        opening = '{12'h000, 12'hFFF, 12'h000, 12'h080, 12'h180, 12'h100, 12'h000,
                    12'h001, 12'h003, 12'h007, 12'h005, 12'h004, 12'h404, 12'h644,
                    12'h640, 12'h377, 12'hCF8, 12'h800, 12'h000, 12'hAAA, 12'h555,
                    12'hFFF, 12'h000};
        n = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (opening[i]) begin
            send_scan(opening[i]);
            idle_sender(($urandom_range(0, 2) == 0) ? $urandom_range(1, 20) : 0);
        end
        keys_now = 12'h000;
        wait_drained();

        while (n < RANDOM_SCANS) begin
            burst = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
            repeat (burst) begin
                // receiver holds off while scans keep coming
                if (n == RANDOM_SCANS / 3) begin
                    hold_asks++;
                end
                if (n == 2 * RANDOM_SCANS / 3) begin
                    wait_drained();
                end
                keys_now = next_scan(keys_now);
                send_scan(keys_now);
                n++;
            end
            idle_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30));
        end

        wait_drained();
        repeat (40) @(posedge i_clk);
        $display("covered %0d scans (%0d directed) giving %0d result items, %0d volume events",
                 scans_sent, $size(opening), results, events);
        $display("with bursty input, patterned output stalls, a long output hold-off and drains");
        if (failures == 0 && pending == 0) begin
            $display("key_matrix_report_builder_core regression: pass");
        end else begin
            $display("key_matrix_report_builder_core regression: fail");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("key_matrix_report_builder_core regression: fail");
        $finish;
    end

endmodule
